@@ src/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 8;
    localparam int PRI_W       = 16;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_PEEK    = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic dequeue;
    } cell_ctrl_t;

endpackage

@@ src/spq_if.sv @@
// Request and response channel interfaces for the sorted priority queue.
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  item_tag;
    logic [15:0] item_priority;

    modport source (output valid, req_type, item_tag, item_priority, input ready);
    modport sink   (input valid, req_type, item_tag, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  head_tag;
    logic [15:0] head_priority;
    logic [4:0]  entry_count;
    logic        queue_empty;

    modport source (output valid, status, head_tag, head_priority, entry_count, queue_empty,
                    input ready);
    modport sink   (input valid, status, head_tag, head_priority, entry_count, queue_empty,
                    output ready);
endinterface

@@ src/spq_cell.sv @@
// One slot of the sorted shift-register array.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_keep,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // stays put on insert: held and not lower than the new item (equal goes behind)
    assign keep  = occupied && (entry_reg.pri >= new_entry.pri);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.dequeue)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, count and response register.
//  channel | modport | beat
//  req     | sink    | req_type, item_tag, item_priority
//  rsp     | source  | status, head_tag, head_priority, entry_count, queue_empty
// One request per cycle unless the response stalls; its response is in the output
// register on the next cycle. Each cell compares its priority with the new item in
// parallel, so an insert or dequeue updates the whole chain together.
// Reset clears the count and response valid; cell contents are ignored until written.
// A stalled response holds req.ready low only while the output register is full.
module sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int D = spq_pkg::QUEUE_DEPTH;
    localparam int W = spq_pkg::CNT_W;

    logic [W-1:0] count_reg;
    logic [W-1:0] count_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    spq_pkg::status_t status_reg;
    spq_pkg::status_t status_next;
    spq_pkg::entry_t  head_reg;
    spq_pkg::entry_t  head_next;

    spq_pkg::entry_t  cell_entry [D];
    logic [D-1:0]     cell_keep;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t  new_entry;

    logic accept;
    logic is_full;
    logic is_empty;
    logic [W+spq_pkg::COUNT_OUT_W-1:0] count_wide;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == W'(D));
    assign is_empty  = (count_reg == '0);

    assign new_entry.tag = req.item_tag;
    assign new_entry.pri = req.item_priority;

    assign ctrl.insert  = accept && (req.req_type == spq_pkg::REQ_INSERT) && !is_full;
    assign ctrl.dequeue = accept && (req.req_type == spq_pkg::REQ_DEQUEUE) && !is_empty;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (W'(i) < count_reg),
            .new_entry   (new_entry),
            .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
            .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == D - 1) ? i : i + 1]),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = spq_pkg::ST_OK;
            head_next      = '0;
            unique case (req.req_type) inside
                spq_pkg::REQ_INSERT:
                begin
                    if (is_full)
                        status_next = spq_pkg::ST_FULL;
                    else
                        count_next = count_reg + W'(1);
                end
                spq_pkg::REQ_DEQUEUE, spq_pkg::REQ_PEEK:
                begin
                    if (is_empty)
                        status_next = spq_pkg::ST_EMPTY;
                    else
                    begin
                        head_next = cell_entry[0];
                        if (req.req_type == spq_pkg::REQ_DEQUEUE)
                            count_next = count_reg - W'(1);
                    end
                end
                default:
                begin
                    status_next = spq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        head_reg   <= head_next;
    end

    // count reported after the request, masked to the port width
    assign count_wide = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.head_tag      = head_reg.tag;
    assign rsp.head_priority = head_reg.pri;
    assign rsp.entry_count   = count_wide[spq_pkg::COUNT_OUT_W-1:0];
    assign rsp.queue_empty   = is_empty;

    // entry_count and queue_empty are live: count only moves on an accepted beat,
    // which needs the response register free or being taken.

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= W'(D))
        else $error("count exceeds depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == spq_pkg::REQ_INSERT) && is_full
        |=> rsp.valid && (rsp.status == spq_pkg::ST_FULL) && $stable(count_reg))
        else $error("insert on full not dropped");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= W'(2)) |-> (cell_entry[0].pri >= cell_entry[1].pri))
        else $error("head out of order");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count moved without a beat");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module testbench;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_REQS = 620;
    localparam int         QUIET_AFTER = 530;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  tag;
        logic [15:0] pri;
        logic [4:0]  count;
        logic        empty;
    } answer_t;

    typedef struct packed {
        logic    pinned;
        answer_t beat;
    } pinned_answer_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tag;
        logic [15:0] pri;
        logic [4:0]  reps;
        logic        shuffle;
        logic        pinned;
        answer_t     beat;
    } stim_row_t;

    localparam int DIR_ROWS = 13;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{spq_pkg::REQ_PEEK,    8'h00, 16'h0000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_EMPTY, 8'h00, 16'h0000, 5'd0,  1'b1}},
        '{spq_pkg::REQ_DEQUEUE, 8'h5A, 16'h1234, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_EMPTY, 8'h00, 16'h0000, 5'd0,  1'b1}},
        '{REQ_UNUSED,           8'hFF, 16'hFFFF, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'h00, 16'h0000, 5'd0,  1'b1}},
        '{spq_pkg::REQ_INSERT,  8'hFF, 16'hFFFF, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'h00, 16'h0000, 5'd1,  1'b0}},
        '{spq_pkg::REQ_INSERT,  8'h00, 16'h0000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'h00, 16'h0000, 5'd2,  1'b0}},
        '{spq_pkg::REQ_INSERT,  8'hA5, 16'hFFFF, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'h00, 16'h0000, 5'd3,  1'b0}},
        '{spq_pkg::REQ_PEEK,    8'h00, 16'h0000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'hFF, 16'hFFFF, 5'd3,  1'b0}},
        '{REQ_UNUSED,           8'h3C, 16'h7777, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'h00, 16'h0000, 5'd3,  1'b0}},
        '{spq_pkg::REQ_DEQUEUE, 8'h00, 16'h0000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'hFF, 16'hFFFF, 5'd2,  1'b0}},
        '{spq_pkg::REQ_DEQUEUE, 8'h00, 16'h0000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_OK,    8'hA5, 16'hFFFF, 5'd1,  1'b0}},
        '{spq_pkg::REQ_INSERT,  8'h00, 16'h0000, 5'd15, 1'b1, 1'b0, '0},
        '{spq_pkg::REQ_INSERT,  8'h77, 16'h8000, 5'd1,  1'b0, 1'b1,
          '{spq_pkg::ST_FULL,  8'h00, 16'h0000, 5'd16, 1'b0}},
        '{spq_pkg::REQ_PEEK,    8'h00, 16'h0000, 5'd1,  1'b0, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [7:0]  held_tag [spq_pkg::QUEUE_DEPTH];
    logic [15:0] held_pri [spq_pkg::QUEUE_DEPTH];
    int          held_num;

    answer_t        awaited_answers [$];
    pinned_answer_t pinned_answers [$];

    int  failures;
    int  cycles;
    int  beats_seen;
    int  n_insert, n_refused, n_dequeue, n_peek, n_empty, n_unused, deepest;
    bit  quiet_tail;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d answers outstanding",
                     cycles, awaited_answers.size());
            $display("FAIL");
            $finish;
        end
    end

    // Shift-array model: head at index 0, ties queue behind older entries.
    function automatic answer_t serve_request(logic [1:0] kind, logic [7:0] tag,
                                              logic [15:0] pri);
        answer_t ans;
        int      pos;
        ans = '0;
        ans.status = spq_pkg::ST_OK;
        if (kind == spq_pkg::REQ_INSERT)
        begin
            if (held_num >= spq_pkg::QUEUE_DEPTH)
                ans.status = spq_pkg::ST_FULL;
            else
            begin
                pos = 0;
                while (pos < held_num && held_pri[pos] >= pri)
                    pos++;
                for (int i = held_num; i > pos; i--)
                begin
                    held_tag[i] = held_tag[i-1];
                    held_pri[i] = held_pri[i-1];
                end
                held_tag[pos] = tag;
                held_pri[pos] = pri;
                held_num++;
            end
        end
        else if (kind == spq_pkg::REQ_DEQUEUE || kind == spq_pkg::REQ_PEEK)
        begin
            if (held_num == 0)
                ans.status = spq_pkg::ST_EMPTY;
            else
            begin
                ans.tag = held_tag[0];
                ans.pri = held_pri[0];
                if (kind == spq_pkg::REQ_DEQUEUE)
                begin
                    for (int i = 1; i < held_num; i++)
                    begin
                        held_tag[i-1] = held_tag[i];
                        held_pri[i-1] = held_pri[i];
                    end
                    held_num--;
                end
            end
        end
        ans.count = held_num[4:0];
        ans.empty = (held_num == 0);
        return ans;
    endfunction

    task automatic report_mismatch(string field, int unsigned want, int unsigned got);
        $display("%0t: answer %0d, %s expected 0x%0h, got 0x%0h", $time, beats_seen, field,
                 want, got);
        failures++;
    endtask

    always @(posedge clk)
    begin
        answer_t        want;
        answer_t        got;
        pinned_answer_t pin;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                want = serve_request(req_ch.req_type, req_ch.item_tag, req_ch.item_priority);
                if (pinned_answers.size() != 0)
                begin
                    pin = pinned_answers.pop_front();
                    if (pin.pinned)
                        want = pin.beat;
                end
                awaited_answers.push_back(want);
                case (req_ch.req_type)
                    spq_pkg::REQ_INSERT:  n_insert++;
                    spq_pkg::REQ_DEQUEUE: n_dequeue++;
                    spq_pkg::REQ_PEEK:    n_peek++;
                    default:              n_unused++;
                endcase
                if (want.status == spq_pkg::ST_FULL)
                    n_refused++;
                if (want.status == spq_pkg::ST_EMPTY)
                    n_empty++;
                if (held_num > deepest)
                    deepest = held_num;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.status, rsp_ch.head_tag, rsp_ch.head_priority,
                        rsp_ch.entry_count, rsp_ch.queue_empty};
                beats_seen++;
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: answer %0d arrived with none expected (status %0d)",
                             $time, beats_seen, got.status);
                    failures++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.tag !== want.tag)
                        report_mismatch("head_tag", want.tag, got.tag);
                    if (got.pri !== want.pri)
                        report_mismatch("head_priority", want.pri, got.pri);
                    if (got.count !== want.count)
                        report_mismatch("entry_count", want.count, got.count);
                    if (got.empty !== want.empty)
                        report_mismatch("queue_empty", want.empty, got.empty);
                end
            end
        end
    end

    // Response back-pressure in bursts, released for good near the end.
    initial
    begin
        rsp_ch.ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            if (!quiet_tail)
                repeat ($urandom_range(0, 24)) @(posedge clk);
        end
    end

    task automatic hold_off();
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_request(logic [1:0] kind, logic [7:0] tag, logic [15:0] pri,
                                pinned_answer_t pin);
        hold_off();
        pinned_answers.push_back(pin);
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.item_tag      <= tag;
        req_ch.item_priority <= pri;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    initial
    begin
        logic [1:0]     kind;
        logic [7:0]     tag;
        logic [15:0]    pri;
        pinned_answer_t pin;
        int             mode;
        int             burst;
        int             roll;
        bit             ties;
        int             random_reqs;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = spq_pkg::REQ_INSERT;
        req_ch.item_tag      = '0;
        req_ch.item_priority = '0;
        held_num             = 0;
        random_reqs          = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
            begin
                tag = DIRECTED[r].tag;
                pri = DIRECTED[r].pri;
                if (DIRECTED[r].shuffle)
                begin
                    tag = 8'($urandom_range(0, 255));
                    pri = 16'($urandom_range(0, 65535));
                end
                pin = '{DIRECTED[r].pinned, DIRECTED[r].beat};
                send_request(DIRECTED[r].kind, tag, pri, pin);
            end
        end

        // Bursts lean towards filling or draining so both full and empty recur.
        while (random_reqs < RANDOM_REQS)
        begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(8, 48);
            ties  = 1'($urandom_range(0, 1));
            for (int k = 0; k < burst && random_reqs < RANDOM_REQS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    kind = REQ_UNUSED;
                else if (roll < (mode == 0 ? 70 : mode == 1 ? 20 : 45))
                    kind = spq_pkg::REQ_INSERT;
                else if (roll < (mode == 0 ? 85 : 80))
                    kind = spq_pkg::REQ_DEQUEUE;
                else
                    kind = spq_pkg::REQ_PEEK;
                tag = 8'($urandom_range(0, 255));
                pri = 16'($urandom_range(0, 65535));
                if (ties)
                begin
                    case ($urandom_range(0, 4))
                        0:       pri = 16'h0000;
                        1:       pri = 16'hFFFF;
                        2:       pri = 16'h8000;
                        default: pri = 16'($urandom_range(0, 3));
                    endcase
                end
                quiet_tail = (random_reqs >= QUIET_AFTER);
                send_request(kind, tag, pri, '0);
                if (kind != REQ_UNUSED)
                    random_reqs++;
            end
        end
        req_ch.valid <= 1'b0;

        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d inserts (%0d refused as full), %0d dequeues, %0d peeks,",
                 n_insert, n_refused, n_dequeue, n_peek);
        $display("%0d unused codes, %0d empty answers, deepest %0d of %0d, %0d answers checked",
                 n_unused, n_empty, deepest, spq_pkg::QUEUE_DEPTH, beats_seen);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
